### hw/rtl/wpso_pkg.sv
// Shared types and constants for the wheel PID speed and odometry core.
package wpso_pkg;

  localparam int unsigned PwmFullScale = 10000;
  localparam int unsigned WheelCount   = 2;

  localparam logic [1:0] ModeRelease  = 2'd0;
  localparam logic [1:0] ModeBrake    = 2'd1;
  localparam logic [1:0] ModeForward  = 2'd2;
  localparam logic [1:0] ModeBackward = 2'd3;

  localparam logic [2:0] RegPropGain  = 3'd0;
  localparam logic [2:0] RegIntegGain = 3'd1;
  localparam logic [2:0] RegDerivGain = 3'd2;
  localparam logic [2:0] RegMmPerTick = 3'd3;

  // Divider: 46-bit dividend (36-bit distance times 1000) by 16-bit duration.
  localparam int unsigned DivBits = 46;

  typedef struct packed {
    logic       start;
    logic       div_step;
    logic       odo;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       pid_prep;
    logic       finish;
  } wpso_cmd_t;

  typedef struct packed {
    logic div_last;
  } wpso_sts_t;

endpackage

### hw/rtl/wheel_pid_speed_odometer_core.sv
// Top level: stream ports, APB register file, controller and datapath.
// One tick per wheel: an item passes through the bit-serial speed divider, then
// odometry, PID prep and three multiply-accumulate steps on one shared gain multiplier;
// one item is in work at a time, and the next is accepted once the previous result has
// moved to the output register.
module wheel_pid_speed_odometer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // target_speed, encoder_ticks, duration_ms
  input  logic        s_axis_tuser,  // wheel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata, // drive_mode, duty, pwm_compare, measured_speed,
                                     // distance_mm, total_ticks, zero fill
  output logic        m_axis_tuser   // wheel_out
);
  import wpso_pkg::*;

  logic [15:0] prop_q, integ_q, deriv_q;
  logic [19:0] mmpt_q;
  logic [2:0]  ridx;
  assign ridx   = paddr[3:2] == 2'd0 ? RegPropGain : {1'b0, paddr[3:2]};
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q  <= 16'd2995;
      integ_q <= 16'd282;
      deriv_q <= 16'd0;
      mmpt_q  <= 20'd65536;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegPropGain:  prop_q  <= pwdata[15:0];
        RegIntegGain: integ_q <= pwdata[15:0];
        RegDerivGain: deriv_q <= pwdata[15:0];
        RegMmPerTick: mmpt_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegPropGain:  prdata = {16'd0, prop_q};
      RegIntegGain: prdata = {16'd0, integ_q};
      RegDerivGain: prdata = {16'd0, deriv_q};
      RegMmPerTick: prdata = {12'd0, mmpt_q};
      default:      prdata = '0;
    endcase
  end

  wpso_cmd_t cmd;
  wpso_sts_t sts;
  logic      busy;
  logic      ovalid_q;
  logic      out_free;
  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = !busy;

  wpso_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_i      (s_axis_tvalid),
    .sts_i      (sts),
    .out_free_i (out_free),
    .busy_o     (busy),
    .cmd_o      (cmd)
  );

  logic [1:0]  mode;
  logic [13:0] duty, cmp;
  logic [31:0] spd, dist_mm, tix;

  wpso_dp u_dp (
    .clk_i, .rst_ni,
    .cmd_i            (cmd),
    .sts_o            (sts),
    .prop_gain_i      (prop_q),
    .integ_gain_i     (integ_q),
    .deriv_gain_i     (deriv_q),
    .mm_per_tick_i    (mmpt_q),
    .wheel_i          (s_axis_tuser),
    .target_speed_i   (s_axis_tdata[15:0]),
    .encoder_ticks_i  (s_axis_tdata[31:16]),
    .duration_ms_i    (s_axis_tdata[47:32]),
    .wheel_o          (m_axis_tuser),
    .drive_mode_o     (mode),
    .duty_o           (duty),
    .pwm_compare_o    (cmp),
    .measured_speed_o (spd),
    .distance_mm_o    (dist_mm),
    .total_ticks_o    (tix)
  );

  assign m_axis_tdata  = {2'b00, tix, dist_mm, spd, cmp, duty, mode};
  assign m_axis_tvalid = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          ovalid_q <= 1'b0;
    else if (cmd.finish)  ovalid_q <= 1'b1;
    else if (m_axis_tready) ovalid_q <= 1'b0;
  end
endmodule

### hw/rtl/wpso_ctrl.sv
// Sequencer for one control tick: divide, odometry, PID prep, three multiplies, output.
module wpso_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_i,
  input  wpso_pkg::wpso_sts_t sts_i,
  input  logic                out_free_i,
  output logic                busy_o,
  output wpso_pkg::wpso_cmd_t cmd_o
);
  import wpso_pkg::*;

  typedef enum logic [7:0] {
    StIdle = 8'b0000_0001,
    StDiv  = 8'b0000_0010,
    StOdo  = 8'b0000_0100,
    StPrep = 8'b0000_1000,
    StMulP = 8'b0001_0000,
    StMulI = 8'b0010_0000,
    StMulD = 8'b0100_0000,
    StDone = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (req_i) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StOdo;
      end
      StOdo: begin
        cmd_o.odo = 1'b1;
        state_d   = StPrep;
      end
      StPrep: begin
        cmd_o.pid_prep = 1'b1;
        state_d        = StMulP;
      end
      StMulP: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = 2'd0;
        state_d        = StMulI;
      end
      StMulI: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = 2'd1;
        state_d        = StMulD;
      end
      StMulD: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_sel  = 2'd2;
        state_d        = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule

### hw/rtl/wpso_dp.sv
// Datapath: per-wheel state, restoring divider, shared gain multiplier.
module wpso_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wpso_pkg::wpso_cmd_t cmd_i,
  output wpso_pkg::wpso_sts_t sts_o,
  input  logic [15:0]         prop_gain_i,
  input  logic [15:0]         integ_gain_i,
  input  logic [15:0]         deriv_gain_i,
  input  logic [19:0]         mm_per_tick_i,
  input  logic                wheel_i,
  input  logic signed [15:0]  target_speed_i,
  input  logic [15:0]         encoder_ticks_i,
  input  logic [15:0]         duration_ms_i,
  output logic                wheel_o,
  output logic [1:0]          drive_mode_o,
  output logic [13:0]         duty_o,
  output logic [13:0]         pwm_compare_o,
  output logic signed [31:0]  measured_speed_o,
  output logic [31:0]         distance_mm_o,
  output logic [31:0]         total_ticks_o
);
  import wpso_pkg::*;

  localparam int unsigned WIdx = $clog2(WheelCount) > 0 ? $clog2(WheelCount) : 1;

  logic [1:0]         mode_q   [WheelCount];
  logic signed [31:0] lerr_q   [WheelCount];
  logic signed [39:0] esum_q   [WheelCount];
  logic [31:0]        speed_q  [WheelCount];
  logic [31:0]        trav_q   [WheelCount];
  logic [15:0]        frac_q   [WheelCount];
  logic [31:0]        ticks_q  [WheelCount];

  logic               w_q;
  logic signed [15:0] tgt_q;
  logic [15:0]        encoder_ticks_q;
  logic [35:0]        dist_q;
  logic [15:0]        dur_q;
  logic [DivBits-1:0] quo_q;
  logic [16:0]        rem_q;
  logic [5:0]         cnt_q;
  logic signed [33:0] err_q;
  logic signed [33:0] der_q;
  logic signed [39:0] sum_q;
  logic signed [59:0] acc_q;
  logic               run_q;
  logic [1:0]         mode_r_q;

  logic [WIdx-1:0] wi;
  assign wi = WIdx'(w_q);

  // dividend: distance times 1000, shifted in MSB first
  logic [DivBits-1:0] dvd;
  logic               dvd_lt;
  assign dvd    = DivBits'(dist_q) * DivBits'(1000);
  assign dvd_lt = {16'd0, dvd[DivBits-1]} < {1'b0, dur_q};

  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh  = {rem_q[15:0], quo_q[DivBits-1]};
  assign rem_sub = rem_sh - {1'b0, dur_q};

  assign sts_o.div_last = (cnt_q == 6'(DivBits - 1));

  // quotient >> 8, saturated
  logic [37:0] q_sh;
  logic [31:0] spd_new;
  assign q_sh    = quo_q[DivBits-1:8];
  assign spd_new = (q_sh > 38'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_sh[31:0];

  logic [36:0] tot;
  assign tot = {1'b0, dist_q} + 37'(frac_q[wi]);

  // PID prep from stored speed
  logic [15:0]        mag;
  logic               want_fwd;
  logic [1:0]         want;
  logic               hold;
  logic               clr;
  logic signed [33:0] err_n;
  logic signed [31:0] lerr_u;
  logic signed [39:0] esum_u;
  logic signed [40:0] s_raw;
  logic signed [39:0] s_sat;
  assign mag      = tgt_q[15] ? 16'(-tgt_q) : tgt_q;
  assign want_fwd = !tgt_q[15];
  assign want     = want_fwd ? ModeForward : ModeBackward;
  assign hold     = (want != mode_q[wi]) && (speed_q[wi] > 32'd256);
  assign clr      = (want != mode_q[wi]) && !hold;
  assign lerr_u   = clr ? 32'sd0 : lerr_q[wi];
  assign esum_u   = clr ? 40'sd0 : esum_q[wi];
  assign err_n    = $signed({10'd0, mag, 8'h00}) - $signed({2'b00, speed_q[wi]});
  assign s_raw    = 41'(esum_u) + 41'(err_n);
  always_comb begin
    if (s_raw > 41'sh07F_FFFF_FFFF)       s_sat = 40'sh7F_FFFF_FFFF;
    else if (s_raw < -41'sh080_0000_0000) s_sat = 40'sh80_0000_0000;
    else                                  s_sat = s_raw[39:0];
  end

  // one gain multiply per cycle
  logic signed [16:0] gain;
  logic signed [39:0] opnd;
  logic signed [59:0] prod;
  always_comb begin
    unique case (cmd_i.mul_sel)
      2'd0:    begin gain = $signed({1'b0, prop_gain_i});  opnd = 40'(err_q); end
      2'd1:    begin gain = $signed({1'b0, integ_gain_i}); opnd = sum_q;      end
      default: begin gain = $signed({1'b0, deriv_gain_i}); opnd = 40'(der_q); end
    endcase
  end
  assign prod = 60'(gain) * 60'(opnd);

  logic [13:0] duty_n;
  logic [43:0] whole;
  assign whole = acc_q[59:16];
  always_comb begin
    if (!run_q || acc_q <= 60'sd0)             duty_n = '0;
    else if (whole > 44'(PwmFullScale))        duty_n = 14'(PwmFullScale);
    else                                       duty_n = whole[13:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WheelCount; i++) begin
        mode_q[i]  <= ModeRelease;
        lerr_q[i]  <= '0;
        esum_q[i]  <= '0;
        speed_q[i] <= '0;
        trav_q[i]  <= '0;
        frac_q[i]  <= '0;
        ticks_q[i] <= '0;
      end
    end else begin
      if (cmd_i.odo) begin
        speed_q[wi] <= spd_new;
        trav_q[wi]  <= trav_q[wi] + 32'(tot[36:16]);
        frac_q[wi]  <= tot[15:0];
        ticks_q[wi] <= ticks_q[wi] + 32'(encoder_ticks_q);
      end
      if (cmd_i.pid_prep && tgt_q != 16'sd0) begin
        if (hold) begin
          mode_q[wi] <= ModeBrake;
        end else begin
          mode_q[wi] <= want;
          lerr_q[wi] <= err_n[31:0];
          esum_q[wi] <= s_sat;
        end
      end else if (cmd_i.pid_prep) begin
        mode_q[wi] <= ModeBrake;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q             <= wheel_i;
      tgt_q           <= target_speed_i;
      encoder_ticks_q <= encoder_ticks_i;
      dist_q          <= 36'(encoder_ticks_i) * 36'(mm_per_tick_i);
      dur_q           <= (duration_ms_i == 16'd0) ? 16'd1 : duration_ms_i;
      cnt_q           <= '0;
      rem_q           <= '0;
    end
    if (cmd_i.div_step) begin
      // first step loads the dividend, shifting as it goes
      if (cnt_q == 6'd0) begin
        rem_q <= dvd_lt ? {16'd0, dvd[DivBits-1]}
                        : 17'({16'd0, dvd[DivBits-1]} - {1'b0, dur_q});
        quo_q <= {dvd[DivBits-2:0], ~dvd_lt};
      end else begin
        rem_q <= rem_sub[16] ? rem_sh : rem_sub;
        quo_q <= {quo_q[DivBits-2:0], ~rem_sub[16]};
      end
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.pid_prep) begin
      run_q    <= (tgt_q != 16'sd0) && !hold;
      mode_r_q <= (tgt_q == 16'sd0 || hold) ? ModeBrake : want;
      err_q    <= err_n;
      der_q    <= err_n - 34'(lerr_u);
      sum_q    <= s_sat;
      acc_q    <= '0;
    end
    if (cmd_i.mul_step) acc_q <= acc_q + prod;
    if (cmd_i.finish) begin
      wheel_o          <= w_q;
      drive_mode_o     <= mode_r_q;
      duty_o           <= duty_n;
      pwm_compare_o    <= 14'(PwmFullScale) - duty_n;
      measured_speed_o <= tgt_q[15] ? -$signed(speed_q[wi]) : $signed(speed_q[wi]);
      distance_mm_o    <= trav_q[wi];
      total_ticks_o    <= ticks_q[wi];
    end
  end
endmodule
